### sv/domain_name_decompressor_assert.svh
// assertion helpers used by the decompressor walker
`ifndef DOMAIN_NAME_DECOMPRESSOR_ASSERT_SVH
`define DOMAIN_NAME_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define DND_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dnd check failed");

// next-cycle implication, disabled while reset is low
`define DND_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dnd check failed");

`endif

### sv/dnd_pkg.sv
// ----------------------------------------------------------------------------
// dnd_pkg
// shared types and constants of the domain name decompressor
// ----------------------------------------------------------------------------
package dnd_pkg;

    localparam int ADDR_W   = 9;   // address field of an input item
    localparam int LEN_W    = 10;  // loaded length, up to 512
    localparam int POS_W    = 15;  // walk position, pointer targets are 14 bits
    localparam int CHUNK_W  = 64;
    localparam int COUNT_W  = 4;
    localparam int RESUME_W = 10;
    localparam int STATUS_W = 2;
    localparam int NAME_W   = 8;   // character count and char buffer index
    localparam int CBUF_DEPTH = 256;

    localparam logic [7:0] LABEL_MAX     = 8'd63;
    localparam logic [7:0] PTR_LOW_MASK  = 8'h3F;
    localparam logic [9:0] NAME_WIRE_MAX = 10'd255;
    localparam logic [7:0] END_BYTE      = 8'd0;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HOPS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LONG  = 2'd3;

    typedef enum logic {
        K_LOAD,
        K_DECODE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  address;
        logic [7:0]         data_byte;
    } t_item;

    // handoff from the front queue to the walker
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LEN,
        S_CHR,
        S_PTR,
        S_EMIT_START,
        S_EMIT_ACC,
        S_EMIT_OUT,
        S_ERR_OUT
    } t_walk_state;

endpackage

### sv/dnd_front.sv
// ----------------------------------------------------------------------------
// dnd_front
// accepts input items, classifies them and queues them for the walker
// ----------------------------------------------------------------------------
module dnd_front #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_action,
    input  logic [dnd_pkg::ADDR_W-1:0] i_address,
    input  logic [7:0]                i_data_byte,
    output dnd_pkg::t_queue_head      o_head,
    input  logic                      i_pop
);

    localparam int DEPTH = 2;

    dnd_pkg::t_item r_fifo [DEPTH];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count, n_count;

    dnd_pkg::t_item w_item;
    logic           w_keep;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_item.kind      = (i_action == dnd_pkg::ACT_DECODE) ? dnd_pkg::K_DECODE
                                                             : dnd_pkg::K_LOAD;
        w_item.address   = i_address;
        w_item.data_byte = i_data_byte;
    end

    // loads past the store are taken and dropped here
    assign w_keep  = (w_item.kind == dnd_pkg::K_DECODE) ||
                     (32'(i_address) < BUFFER_BYTES);
    assign o_ready = (r_count != 2'(DEPTH));
    assign w_push  = i_valid && o_ready && w_keep;
    assign w_pop   = i_pop && (r_count != 2'd0);

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_fifo[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_item;
        end
    end

endmodule

### sv/dnd_walk.sv
// ----------------------------------------------------------------------------
// dnd_walk
// packet store, label and pointer walker, char buffer and result register
// ----------------------------------------------------------------------------
`include "domain_name_decompressor_assert.svh"

module dnd_walk #(
    parameter int BUFFER_BYTES = 512,
    parameter int MAX_HOPS     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dnd_pkg::t_queue_head          i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dnd_pkg::CHUNK_W-1:0]   o_name_chunk,
    output logic [dnd_pkg::COUNT_W-1:0]   o_chunk_count,
    output logic [dnd_pkg::RESUME_W-1:0]  o_resume_offset,
    output logic [dnd_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int HW = $clog2(MAX_HOPS + 1);

    // memories
    logic [7:0] r_store [BUFFER_BYTES];
    logic [7:0] r_cbuf  [dnd_pkg::CBUF_DEPTH];
    logic [7:0] r_store_q;
    logic [7:0] r_cbuf_q;

    dnd_pkg::t_walk_state r_state, n_state;

    logic [dnd_pkg::LEN_W-1:0]    r_len, n_len;
    logic [dnd_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [5:0]                   r_cnt, n_cnt;
    logic [dnd_pkg::NAME_W-1:0]   r_n, n_n;
    logic [7:0]                   r_wire, n_wire;
    logic [HW-1:0]                r_hops, n_hops;
    logic                         r_jumped, n_jumped;
    logic [dnd_pkg::RESUME_W-1:0] r_resume, n_resume;
    logic [5:0]                   r_ptr_hi, n_ptr_hi;
    logic [dnd_pkg::STATUS_W-1:0] r_status, n_status;
    logic [dnd_pkg::NAME_W-1:0]   r_k, n_k;
    logic [3:0]                   r_j, n_j;
    logic [3:0]                   r_c, n_c;
    logic [dnd_pkg::CHUNK_W-1:0]  r_chunk, n_chunk;

    logic                          r_out_valid, n_out_valid;
    logic [dnd_pkg::CHUNK_W-1:0]   r_out_chunk, n_out_chunk;
    logic [dnd_pkg::COUNT_W-1:0]   r_out_count, n_out_count;
    logic [dnd_pkg::RESUME_W-1:0]  r_out_resume, n_out_resume;
    logic [dnd_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic                          r_out_last, n_out_last;

    // memory controls
    logic                          w_st_we;
    logic [AW-1:0]                 w_st_waddr;
    logic [dnd_pkg::POS_W-1:0]     w_st_raddr;
    logic                          w_cb_we;
    logic [dnd_pkg::NAME_W-1:0]    w_cb_raddr;

    // decode of the current walk byte
    logic [dnd_pkg::POS_W-1:0] w_len_ext;
    logic [dnd_pkg::POS_W-1:0] w_pos1;
    logic                      w_pos_oob;
    logic                      w_ptr_oob;
    logic                      w_lbl_oob;
    logic                      w_is_end;
    logic                      w_is_ptr;
    logic                      w_too_long;
    logic                      w_hops_max;
    logic                      w_out_free;
    logic                      w_is_decode;
    logic [dnd_pkg::NAME_W-1:0] w_rem;
    logic [3:0]                w_c;
    logic                      w_chunk_last;
    logic                      w_acc_done;

    assign w_len_ext  = dnd_pkg::POS_W'(r_len);
    assign w_pos1     = r_pos + 15'd1;
    assign w_pos_oob  = (r_pos >= w_len_ext);
    assign w_ptr_oob  = (w_pos1 >= w_len_ext);
    assign w_lbl_oob  = ((r_pos + {7'd0, r_store_q}) >= w_len_ext);
    assign w_is_end   = (r_store_q == dnd_pkg::END_BYTE);
    assign w_is_ptr   = (r_store_q > dnd_pkg::LABEL_MAX);
    // wire length with this label and the closing zero
    assign w_too_long = (({2'd0, r_wire} + {2'd0, r_store_q} + 10'd2) >
                         dnd_pkg::NAME_WIRE_MAX);
    assign w_hops_max = (r_hops == HW'(MAX_HOPS));
    assign w_out_free = !r_out_valid || i_ready;
    assign w_is_decode = (i_head.item.kind == dnd_pkg::K_DECODE);
    assign w_rem      = r_n - r_k;
    assign w_c        = (w_rem > 8'd8) ? 4'd8 : w_rem[3:0];
    assign w_chunk_last = (({1'b0, r_k} + {5'd0, r_c}) >= {1'b0, r_n});
    assign w_acc_done = ((r_j + 4'd1) == r_c);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dnd_pkg::S_IDLE: begin
                if (i_head.valid && w_is_decode) begin
                    n_state = dnd_pkg::S_CHECK;
                end
            end
            dnd_pkg::S_CHECK: begin
                n_state = w_pos_oob ? dnd_pkg::S_ERR_OUT : dnd_pkg::S_LEN;
            end
            dnd_pkg::S_LEN: begin
                if (w_is_end) begin
                    n_state = dnd_pkg::S_EMIT_START;
                end else if (w_is_ptr) begin
                    n_state = w_ptr_oob ? dnd_pkg::S_ERR_OUT : dnd_pkg::S_PTR;
                end else if (w_lbl_oob || w_too_long) begin
                    n_state = dnd_pkg::S_ERR_OUT;
                end else begin
                    n_state = dnd_pkg::S_CHR;
                end
            end
            dnd_pkg::S_CHR: begin
                if (r_cnt == 6'd1) begin
                    n_state = dnd_pkg::S_CHECK;
                end
            end
            dnd_pkg::S_PTR: begin
                n_state = w_hops_max ? dnd_pkg::S_ERR_OUT : dnd_pkg::S_CHECK;
            end
            dnd_pkg::S_EMIT_START: begin
                n_state = (w_c == 4'd0) ? dnd_pkg::S_EMIT_OUT : dnd_pkg::S_EMIT_ACC;
            end
            dnd_pkg::S_EMIT_ACC: begin
                if (w_acc_done) begin
                    n_state = dnd_pkg::S_EMIT_OUT;
                end
            end
            dnd_pkg::S_EMIT_OUT: begin
                if (w_out_free) begin
                    n_state = w_chunk_last ? dnd_pkg::S_IDLE : dnd_pkg::S_EMIT_START;
                end
            end
            dnd_pkg::S_ERR_OUT: begin
                if (w_out_free) begin
                    n_state = dnd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dnd_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_len        = r_len;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_n          = r_n;
        n_wire       = r_wire;
        n_hops       = r_hops;
        n_jumped     = r_jumped;
        n_resume     = r_resume;
        n_ptr_hi     = r_ptr_hi;
        n_status     = r_status;
        n_k          = r_k;
        n_j          = r_j;
        n_c          = r_c;
        n_chunk      = r_chunk;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_chunk  = r_out_chunk;
        n_out_count  = r_out_count;
        n_out_resume = r_out_resume;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        w_st_we      = 1'b0;
        w_st_waddr   = AW'(i_head.item.address);
        w_st_raddr   = r_pos;
        w_cb_we      = 1'b0;
        w_cb_raddr   = r_k;
        case (r_state)
            dnd_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (w_is_decode) begin
                        n_pos    = dnd_pkg::POS_W'(i_head.item.address);
                        n_n      = '0;
                        n_wire   = '0;
                        n_hops   = '0;
                        n_jumped = 1'b0;
                        n_resume = '0;
                        n_k      = '0;
                    end else begin
                        w_st_we = 1'b1;
                        if ((dnd_pkg::LEN_W'(i_head.item.address) + 10'd1) > r_len) begin
                            n_len = dnd_pkg::LEN_W'(i_head.item.address) + 10'd1;
                        end
                    end
                end
            end
            dnd_pkg::S_CHECK: begin
                w_st_raddr = r_pos;
                if (w_pos_oob) begin
                    n_status = dnd_pkg::ST_RANGE;
                end
            end
            dnd_pkg::S_LEN: begin
                w_st_raddr = w_pos1;
                if (w_is_end) begin
                    if (!r_jumped) begin
                        n_resume = dnd_pkg::RESUME_W'(w_pos1);
                    end
                end else if (w_is_ptr) begin
                    n_ptr_hi = r_store_q[5:0] & dnd_pkg::PTR_LOW_MASK[5:0];
                    if (w_ptr_oob) begin
                        n_status = dnd_pkg::ST_RANGE;
                    end
                end else if (w_lbl_oob) begin
                    n_status = dnd_pkg::ST_RANGE;
                end else if (w_too_long) begin
                    n_status = dnd_pkg::ST_LONG;
                end else begin
                    n_cnt  = r_store_q[5:0];
                    n_wire = r_wire + r_store_q + 8'd1;
                    n_pos  = w_pos1;
                end
            end
            dnd_pkg::S_CHR: begin
                w_cb_we    = 1'b1;
                w_st_raddr = w_pos1;
                n_n        = r_n + 8'd1;
                n_cnt      = r_cnt - 6'd1;
                n_pos      = w_pos1;
            end
            dnd_pkg::S_PTR: begin
                if (w_hops_max) begin
                    n_status = dnd_pkg::ST_HOPS;
                end else begin
                    n_hops = r_hops + HW'(1);
                    if (!r_jumped) begin
                        n_resume = dnd_pkg::RESUME_W'(r_pos + 15'd2);
                        n_jumped = 1'b1;
                    end
                    n_pos = {1'b0, r_ptr_hi, r_store_q};
                end
            end
            dnd_pkg::S_EMIT_START: begin
                w_cb_raddr = r_k;
                n_c        = w_c;
                n_j        = '0;
                n_chunk    = '0;
            end
            dnd_pkg::S_EMIT_ACC: begin
                w_cb_raddr = r_k + {4'd0, r_j} + 8'd1;
                for (int i = 0; i < 8; i++) begin
                    if (r_j == 4'(i)) begin
                        n_chunk[8*i +: 8] = r_cbuf_q;
                    end
                end
                n_j = r_j + 4'd1;
            end
            dnd_pkg::S_EMIT_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_chunk  = r_chunk;
                    n_out_count  = r_c;
                    n_out_resume = r_resume;
                    n_out_status = dnd_pkg::ST_OK;
                    n_out_last   = w_chunk_last;
                    n_k          = r_k + {4'd0, r_c};
                end
            end
            dnd_pkg::S_ERR_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_chunk  = '0;
                    n_out_count  = '0;
                    n_out_resume = '0;
                    n_out_status = r_status;
                    n_out_last   = 1'b1;
                end
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dnd_pkg::S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_cnt        <= n_cnt;
        r_n          <= n_n;
        r_wire       <= n_wire;
        r_hops       <= n_hops;
        r_jumped     <= n_jumped;
        r_resume     <= n_resume;
        r_ptr_hi     <= n_ptr_hi;
        r_status     <= n_status;
        r_k          <= n_k;
        r_j          <= n_j;
        r_c          <= n_c;
        r_chunk      <= n_chunk;
        r_out_chunk  <= n_out_chunk;
        r_out_count  <= n_out_count;
        r_out_resume <= n_out_resume;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    // packet store, the walk uses only bytes that lie below the loaded length
    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            r_store[w_st_waddr] <= i_head.item.data_byte;
        end
        r_store_q <= r_store[AW'(w_st_raddr)];
    end

    // collected name characters
    always_ff @(posedge i_clk) begin
        if (w_cb_we) begin
            r_cbuf[r_n] <= r_store_q;
        end
        r_cbuf_q <= r_cbuf[w_cb_raddr];
    end

    assign o_valid         = r_out_valid;
    assign o_name_chunk    = r_out_chunk;
    assign o_chunk_count   = r_out_count;
    assign o_resume_offset = r_out_resume;
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;

    `DND_ASSERT_IMPLY(a_err_result_empty, i_clk, i_rst_n,
        r_out_valid && (r_out_status != dnd_pkg::ST_OK),
        (r_out_chunk == '0) && (r_out_count == '0) && r_out_last)
    `DND_ASSERT_IMPLY(a_count_max, i_clk, i_rst_n,
        r_out_valid, r_out_count <= 4'd8)
    `DND_ASSERT_IMPLY(a_len_in_store, i_clk, i_rst_n,
        1'b1, 32'(r_len) <= BUFFER_BYTES)
    `DND_ASSERT_NEXT(a_hop_limit, i_clk, i_rst_n,
        (r_state == dnd_pkg::S_PTR) && w_hops_max,
        (r_state == dnd_pkg::S_ERR_OUT) && (r_status == dnd_pkg::ST_HOPS))

endmodule

### sv/domain_name_decompressor.sv
// a load is written to the store by the idle walker once it leaves the two-entry input queue
// a decode passes check and length per label, pointer and closing zero, a character state
// per character, a pointer state per pointer, start, accumulate and output per chunk
// the walker reads one packet store byte per cycle and takes the next item only when idle
// reset (synchronous, active low) empties the queue and clears the loaded length
// store is not cleared: unwritten bytes below the loaded length can be read by the walk
// ----------------------------------------------------------------------------
// domain_name_decompressor
// loads response bytes and decodes compressed domain names into 8-byte chunks
// ----------------------------------------------------------------------------
module domain_name_decompressor #(
    parameter int BUFFER_BYTES = 512,
    parameter int MAX_HOPS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address[8:0], data_byte[16:9], zero pad
    input  logic [0:0]  s_axis_tuser,   // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // name_chunk[63:0], chunk_count[67:64],
                                        // resume_offset[77:68], zero pad
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast    // last
);

    dnd_pkg::t_queue_head w_head;
    logic                 w_pop;

    logic [dnd_pkg::CHUNK_W-1:0]  w_chunk;
    logic [dnd_pkg::COUNT_W-1:0]  w_count;
    logic [dnd_pkg::RESUME_W-1:0] w_resume;

    dnd_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (s_axis_tuser[0]),
        .i_address   (s_axis_tdata[8:0]),
        .i_data_byte (s_axis_tdata[16:9]),
        .o_head      (w_head),
        .i_pop       (w_pop)
    );

    dnd_walk #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_HOPS     (MAX_HOPS)
    ) u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_name_chunk    (w_chunk),
        .o_chunk_count   (w_count),
        .o_resume_offset (w_resume),
        .o_status        (m_axis_tuser),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_resume, w_count, w_chunk};

endmodule

### tb/sv/domain_name_decompressor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// domain_name_decompressor_test
// loads response bytes into the decompressor's packet store and decodes
// names from them: plain labels, compression pointers (nested, reserved
// types, loops), offsets past the loaded length, hop and length limits,
// then random messages under random sender gaps and receiver stalls. every
// result chunk is checked against a predictor kept in the bench.
// ----------------------------------------------------------------------------
module domain_name_decompressor_test;

    localparam int BUFFER_BYTES  = 512;
    localparam int MAX_HOPS      = 16;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_ITEMS  = 30;
    localparam int SETTLE_CYCLES = 800;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int STALL_CYCLES  = 600;

    // top two bits of a length byte
    localparam logic [1:0] TAG_PTR   = 2'b11;
    localparam logic [1:0] TAG_RSV_A = 2'b01;
    localparam logic [1:0] TAG_RSV_B = 2'b10;

    typedef struct packed {
        logic [dnd_pkg::CHUNK_W-1:0]  chunk;
        logic [dnd_pkg::COUNT_W-1:0]  count;
        logic [dnd_pkg::RESUME_W-1:0] resume;
        logic [dnd_pkg::STATUS_W-1:0] status;
        logic                         last;
    } t_name_chunk;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_COMB,
        RX_SPARSE
    } t_rx_pattern;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // address[8:0], data_byte[16:9], zero pad
    logic [0:0]  s_axis_tuser  = '0;    // action[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // name_chunk[63:0], chunk_count[67:64],
                                        // resume_offset[77:68], zero pad
    logic [1:0]  m_axis_tuser;          // status[1:0]
    logic        m_axis_tlast;

    // mirror of the packet store
    logic [7:0]  pkt_mem [BUFFER_BYTES];
    bit          pkt_written [BUFFER_BYTES];
    int          pkt_len = 0;

    t_name_chunk expected_chunks[$];
    t_name_chunk walk_chunks[$];
    logic [7:0]  msg_bytes[$];
    int          name_starts[$];

    int          mismatches = 0;
    int          items_sent = 0;
    int          tx_burst_left = 0;
    bit          tx_valid_up = 1'b0;
    bit          tx_gaps_on = 1'b1;
    int          hold_token = 0;
    int          hold_len = 0;

    domain_name_decompressor #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .MAX_HOPS    (MAX_HOPS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void append_byte(input logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    function automatic void append_start(input int s);
        name_starts.insert(name_starts.size(), s);
    endfunction

    function automatic void append_chunk(input t_name_chunk r);
        walk_chunks.insert(walk_chunks.size(), r);
    endfunction

    // walks the mirrored store from start and fills walk_chunks; returns the
    // first never-written position the walk would read, or -1
    function automatic int walk_name(input int start);
        logic [7:0]                   chars [256];
        logic [7:0]                   b;
        logic [dnd_pkg::CHUNK_W-1:0]  chunk;
        logic [dnd_pkg::STATUS_W-1:0] st;
        t_name_chunk                  r;
        int                           pos, tgt, n, wire_len, hops, resume, k, c;
        bit                           jumped;
        st = dnd_pkg::ST_OK;
        pos = start;
        n = 0;
        wire_len = 0;
        hops = 0;
        resume = 0;
        jumped = 1'b0;
        walk_chunks.delete();
        while (1) begin
            if (pos >= pkt_len) begin
                st = dnd_pkg::ST_RANGE;
                break;
            end
            if (!pkt_written[pos]) return pos;
            b = pkt_mem[pos];
            if (b == dnd_pkg::END_BYTE) begin
                if (!jumped) resume = pos + 1;
                break;
            end
            if (b > dnd_pkg::LABEL_MAX) begin
                if (pos + 1 >= pkt_len) begin
                    st = dnd_pkg::ST_RANGE;
                    break;
                end
                if (!pkt_written[pos + 1]) return pos + 1;
                tgt = {b & dnd_pkg::PTR_LOW_MASK, pkt_mem[pos + 1]};
                if (!jumped) begin
                    resume = pos + 2;
                    jumped = 1'b1;
                end
                hops++;
                if (hops > MAX_HOPS) begin
                    st = dnd_pkg::ST_HOPS;
                    break;
                end
                pos = tgt;
                continue;
            end
            if (pos + b >= pkt_len) begin
                st = dnd_pkg::ST_RANGE;
                break;
            end
            // wire length counts length bytes, characters and the final zero
            if (wire_len + b + 2 > dnd_pkg::NAME_WIRE_MAX) begin
                st = dnd_pkg::ST_LONG;
                break;
            end
            for (k = 1; k <= b; k++) begin
                if (!pkt_written[pos + k]) return pos + k;
                chars[n + k - 1] = pkt_mem[pos + k];
            end
            n += b;
            wire_len += b + 1;
            pos += b + 1;
        end
        if (st != dnd_pkg::ST_OK) begin
            r = '0;
            r.status = st;
            r.last = 1'b1;
            append_chunk(r);
            return -1;
        end
        k = 0;
        do begin
            c = (n - k > 8) ? 8 : n - k;
            chunk = '0;
            for (int j = 0; j < c; j++) chunk[8*j +: 8] = chars[k + j];
            k += c;
            r.chunk = chunk;
            r.count = dnd_pkg::COUNT_W'(c);
            r.resume = dnd_pkg::RESUME_W'(resume);
            r.status = dnd_pkg::ST_OK;
            r.last = (k >= n);
            append_chunk(r);
        end while (k < n);
        return -1;
    endfunction

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) $display("mismatch %0s: expected %h, got %h", what, want, got);
    endfunction

    function automatic int pick_start();
        return name_starts[$urandom_range(0, name_starts.size() - 1)];
    endfunction

    function automatic void add_label(input string s);
        append_byte(8'(s.len()));
        for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    endfunction

    function automatic void add_random_label(input int len);
        append_byte(8'(len));
        repeat (len) append_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_pointer(input logic [1:0] tag, input int tgt);
        logic [13:0] t;
        t = 14'(tgt);
        append_byte({tag, t[13:8]});
        append_byte(t[7:0]);
    endfunction

    // one transfer on the input side, with bursts and random gaps
    task automatic send_item(input logic act, input logic [dnd_pkg::ADDR_W-1:0] addr,
                             input logic [7:0] data);
        int gap;
        if (tx_burst_left == 0) begin
            gap = (tx_gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
            tx_burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                if (tx_valid_up) s_axis_tvalid <= 1'b0;
                tx_valid_up = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        tx_burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, data, addr};
        s_axis_tuser <= act;
        tx_valid_up = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic load_byte(input int addr, input logic [7:0] data);
        pkt_mem[addr] = data;
        pkt_written[addr] = 1'b1;
        if (addr + 1 > pkt_len) pkt_len = addr + 1;
        send_item(dnd_pkg::ACT_LOAD, dnd_pkg::ADDR_W'(addr), data);
    endtask

    // bytes that would fall past the store are dropped
    task automatic load_msg(input int base);
        foreach (msg_bytes[i]) begin
            if (base + i < BUFFER_BYTES) load_byte(base + i, msg_bytes[i]);
        end
        msg_bytes.delete();
    endtask

    task automatic decode_name(input int addr);
        int hole;
        // never let the walk touch a byte that was not loaded
        hole = walk_name(addr);
        while (hole >= 0) begin
            load_byte(hole, ($urandom_range(0, 1) != 0) ? dnd_pkg::END_BYTE
                                                        : 8'($urandom_range(0, 255)));
            hole = walk_name(addr);
        end
        expected_chunks = {expected_chunks, walk_chunks};
        send_item(dnd_pkg::ACT_DECODE, dnd_pkg::ADDR_W'(addr), 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        if (tx_valid_up) s_axis_tvalid <= 1'b0;
        tx_valid_up = 1'b0;
        do @(posedge i_clk); while (expected_chunks.size() != 0);
    endtask

    task automatic test_plain_names();
        add_label("www");
        add_label("example");
        add_label("com");
        append_byte(dnd_pkg::END_BYTE);
        load_msg(0);
        decode_name(0);
        decode_name(4);
        decode_name(16);    // empty name
        append_start(0);
        append_start(4);
        append_start(16);
    endtask

    task automatic test_pointer_follow();
        add_label("mail");
        add_pointer(TAG_PTR, 4);        // 17: mail -> example.com
        add_pointer(TAG_PTR, 17);       // 24: pointer to the name at 17
        add_pointer(TAG_RSV_A, 12);     // 26: reserved type taken as pointer
        add_pointer(TAG_RSV_B, 14'h3FFF); // 28: target far past the store
        load_msg(17);
        decode_name(17);
        decode_name(24);
        decode_name(26);
        decode_name(28);
        append_start(17);
        append_start(24);
    endtask

    task automatic test_range_errors();
        decode_name(300);
        // label running past the loaded bytes, then a pointer cut in half
        append_byte(8'd5);
        append_byte("a");
        append_byte("b");
        append_byte({TAG_PTR, 6'd0});
        load_msg(30);
        decode_name(30);
        decode_name(33);
        decode_name(34);
    endtask

    task automatic test_hop_and_length_limits();
        add_pointer(TAG_PTR, 34);       // pointer to itself
        load_msg(34);
        decode_name(34);
        // 14-char label looping on itself runs out of wire length first
        add_random_label(14);
        add_pointer(TAG_PTR, 36);
        load_msg(36);
        decode_name(36);
        // 1-char label looping on itself runs out of hops first
        add_random_label(1);
        add_pointer(TAG_PTR, 53);
        load_msg(53);
        decode_name(53);
    endtask

    task automatic test_store_edges();
        decode_name(BUFFER_BYTES - 1);
        load_byte(BUFFER_BYTES - 1, dnd_pkg::END_BYTE);
        decode_name(BUFFER_BYTES - 1);  // resume offset one past the store
    endtask

    task automatic test_longest_name();
        // 35 characters, five chunks with a short last one
        add_random_label(12);
        add_random_label(12);
        add_random_label(11);
        append_byte(dnd_pkg::END_BYTE);
        load_msg(256);
        decode_name(256);
        append_start(256);
        wait_drained();
    endtask

    task automatic test_random_names();
        int goal, base, start, tgt, here, roll;
        int fresh[$];
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            base = $urandom_range(0, BUFFER_BYTES - 1);
            fresh.delete();
            repeat ($urandom_range(1, 2)) begin
                start = base + msg_bytes.size();
                if ($urandom_range(0, 5) == 0) begin
                    // chain of pointers, around the hop limit
                    tgt = pick_start();
                    repeat ($urandom_range(1, MAX_HOPS + 2)) begin
                        here = base + msg_bytes.size();
                        add_pointer(TAG_PTR, tgt);
                        tgt = here;
                    end
                    start = tgt;
                end else begin
                    repeat ($urandom_range(0, 3)) begin
                        add_random_label(($urandom_range(0, 9) == 0) ? $urandom_range(11, 63)
                                                                     : $urandom_range(1, 10));
                    end
                    roll = $urandom_range(0, 9);
                    if (roll < 5) append_byte(dnd_pkg::END_BYTE);
                    else if (roll < 9) add_pointer(TAG_PTR, pick_start());
                    else add_pointer(2'($urandom_range(1, 3)), $urandom_range(0, 16383));
                end
                if (start < BUFFER_BYTES) fresh = {fresh, start};
            end
            load_msg(base);
            foreach (fresh[i]) begin
                decode_name(fresh[i]);
                append_start(fresh[i]);
            end
            repeat ($urandom_range(0, 2)) decode_name(pick_start());
            if ($urandom_range(0, 3) == 0) decode_name($urandom_range(0, BUFFER_BYTES - 1));
        end
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_output_stall();
        hold_len = STALL_CYCLES;
        hold_token++;
        tx_gaps_on = 1'b0;
        tx_burst_left = 0;
        // long names keep the block busy while the receiver holds off
        repeat (6) decode_name(256);
        repeat (4) decode_name(pick_start());
        wait_drained();
        tx_gaps_on = 1'b1;
    endtask

    // receiver ready pattern, plus a long hold when requested
    t_rx_pattern rx_pattern = RX_OPEN;
    int rx_phase_left = 0;
    int rx_tick = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge i_clk) begin
        rx_tick++;
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_pattern = t_rx_pattern'($urandom_range(0, 3));
                rx_phase_left = $urandom_range(16, 160);
            end else begin
                rx_phase_left--;
            end
            case (rx_pattern)
                RX_OPEN: begin
                    m_axis_tready <= 1'b1;
                end
                RX_COIN: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                RX_COMB: begin
                    m_axis_tready <= (rx_tick % 5) != 0;
                end
                default: begin
                    m_axis_tready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        t_name_chunk got;
        t_name_chunk want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.chunk = m_axis_tdata[63:0];
            got.count = m_axis_tdata[67:64];
            got.resume = m_axis_tdata[77:68];
            got.status = m_axis_tuser;
            got.last = m_axis_tlast;
            if (expected_chunks.size() == 0) begin
                flag_mismatch("unexpected chunk", '0, got.chunk);
            end else begin
                want = expected_chunks.pop_front();
                if (got.chunk !== want.chunk) flag_mismatch("name_chunk", want.chunk, got.chunk);
                if (got.count !== want.count) flag_mismatch("chunk_count", want.count, got.count);
                if (got.resume !== want.resume)
                    flag_mismatch("resume_offset", want.resume, got.resume);
                if (got.status !== want.status) flag_mismatch("status", want.status, got.status);
                if (got.last !== want.last) flag_mismatch("last", want.last, got.last);
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_plain_names();
        test_pointer_follow();
        test_range_errors();
        test_hop_and_length_limits();
        test_store_edges();
        test_longest_name();
        test_output_stall();
        test_random_names();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_chunks.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
